// ----- rtl/bwrp_pkg.sv -----
// bwrp_pkg: shared types for the budgeted weighted random pick block
// op codes, sequencer states, shared unit operations, table entry layout
// no dependencies
`timescale 1ns / 1ps

package bwrp_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_DRAW   = 2'd1,
      OP_BUDGET = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      UOP_HOLD,
      UOP_CLEAR,
      UOP_SUM,
      UOP_MUL,
      UOP_SCAN
   } uop_type;

   typedef struct packed {
      logic [7:0]         kind;
      logic [15:0]        weight;
      logic [7:0]         cost;
      logic signed [11:0] min_height;
      logic signed [11:0] max_height;
   } option_type;

   typedef struct packed {
      logic       eligible;
      logic       hit;
      logic       total_zero;
      logic       last_valid;
      logic [7:0] last_kind;
      logic [7:0] last_cost;
   } unit_status_type;

endpackage

// ----- rtl/bwrp_table.sv -----
// bwrp_table: option table, one write port and one registered read port
// depends on bwrp_pkg for the entry layout
`timescale 1ns / 1ps

module bwrp_table
   import bwrp_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  option_type       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output option_type       rd_data_ff
);

   option_type mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/bwrp_unit.sv -----
// bwrp_unit: shared eligibility check, weight accumulator and roll scaler
// depends on bwrp_pkg for the entry layout, unit operations and status
`timescale 1ns / 1ps

module bwrp_unit
   import bwrp_pkg::*;
#(
   parameter int SUM_W = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  uop_type            uop,
   input  option_type         entry,
   input  logic signed [11:0] height,
   input  logic [15:0]        budget,
   input  logic [15:0]        roll,
   output unit_status_type    status
);

   logic [SUM_W-1:0]    acc_ff;
   logic [SUM_W-1:0]    scaled_ff;
   logic                last_valid_ff;
   logic [7:0]          last_kind_ff;
   logic [7:0]          last_cost_ff;
   logic [SUM_W-1:0]    acc_sum;
   logic [SUM_W+15:0]   product;
   logic                eligible;

   assign eligible = (entry.weight != 16'd0)
                   && ({8'd0, entry.cost} <= budget)
                   && (height >= $signed(entry.min_height))
                   && (height <= $signed(entry.max_height));

   assign acc_sum = acc_ff + SUM_W'(entry.weight);
   assign product = {{SUM_W{1'b0}}, roll} * {16'd0, acc_ff};

   always_ff @(posedge clock) begin
      case (uop)
         UOP_CLEAR: begin
            acc_ff <= '0;
         end
         UOP_SUM: begin
            if (eligible) begin
               acc_ff <= acc_sum;
            end
         end
         UOP_MUL: begin
            // scaled roll = (roll * total) >> 16
            scaled_ff <= product[SUM_W+15:16];
            acc_ff    <= '0;
         end
         UOP_SCAN: begin
            if (eligible) begin
               acc_ff       <= acc_sum;
               last_kind_ff <= entry.kind;
               last_cost_ff <= entry.cost;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else if (uop == UOP_MUL || uop == UOP_CLEAR) begin
         last_valid_ff <= 1'b0;
      end else if (uop == UOP_SCAN && eligible) begin
         last_valid_ff <= 1'b1;
      end
   end

   always_comb begin
      status.eligible   = eligible;
      status.hit        = eligible && (scaled_ff < acc_sum);
      status.total_zero = (acc_ff == '0);
      status.last_valid = last_valid_ff;
      status.last_kind  = last_kind_ff;
      status.last_cost  = last_cost_ff;
   end

endmodule

// ----- rtl/budgeted_weighted_random_pick_core.sv -----
// Budgeted weighted random pick. Keeps up to MAX_OPTIONS options (type, Q4.12 weight, cost,
// height band) and a 16-bit budget. A load or budget reload goes straight to the finish state.
// A draw over n entries in use runs in order: a pass over the entries sums the eligible
// weights, the roll is scaled, a second pass, skipped if no weight is eligible, finds the pick,
// and the result is posted once the result register is free. Both passes use the single
// accumulate/compare unit and the table's one read port, one entry a cycle.
// The result register lets the next item be taken while a result waits on rsp_stall.
// The table holds no valid bits; drawing over a slot never loaded gives no defined pick.
`timescale 1ns / 1ps

module budgeted_weighted_random_pick_core
   import bwrp_pkg::*;
#(
   parameter int MAX_OPTIONS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [2:0]         req_entry_index,
   input  logic [7:0]         req_entry_type,
   input  logic [15:0]        req_entry_weight,
   input  logic [7:0]         req_entry_cost,
   input  logic signed [11:0] req_entry_min_height,
   input  logic signed [11:0] req_entry_max_height,
   input  logic [15:0]        req_budget_value,
   input  logic signed [11:0] req_height,
   input  logic [15:0]        req_roll,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [7:0]         rsp_chosen_type,
   output logic [15:0]        rsp_budget_left,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_option_count
);

   localparam int IDX_W = $clog2(MAX_OPTIONS);
   localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
   localparam int SUM_W = 16 + $clog2(MAX_OPTIONS);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [15:0]        budget_ff, budget_in;
   logic               found_ff, found_in;
   logic [7:0]         kind_ff, kind_in;
   logic signed [11:0] height_ff;
   logic [15:0]        roll_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [7:0]         rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_budget_ff, rsp_budget_in;

   uop_type            uop;
   unit_status_type    status;
   option_type         rd_data;
   option_type         wr_data;
   logic               tbl_we;
   logic               req_xfer;
   logic               last_entry;

   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen_type = rsp_kind_ff;
   assign rsp_budget_left = rsp_budget_ff;

   assign last_entry = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));

   always_comb begin
      wr_data.kind       = req_entry_type;
      wr_data.weight     = req_entry_weight;
      wr_data.cost       = req_entry_cost;
      wr_data.min_height = req_entry_min_height;
      wr_data.max_height = req_entry_max_height;
   end

   // count above the table depth saturates
   always_comb begin
      if (int'(csr_option_count) > MAX_OPTIONS) begin
         count_in = CNT_W'(MAX_OPTIONS);
      end else begin
         count_in = CNT_W'(csr_option_count);
      end
   end

   bwrp_table #(
      .DEPTH (MAX_OPTIONS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (IDX_W'(req_entry_index)),
      .wr_data    (wr_data),
      .rd_addr    (idx_in),
      .rd_data_ff (rd_data)
   );

   bwrp_unit #(
      .SUM_W (SUM_W)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .uop    (uop),
      .entry  (rd_data),
      .height (height_ff),
      .budget (budget_ff),
      .roll   (roll_ff),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         budget_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      kind_ff       <= kind_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_budget_ff <= rsp_budget_in;
      if (req_xfer) begin
         height_ff <= req_height;
         roll_ff   <= req_roll;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      budget_in     = budget_ff;
      found_in      = found_ff;
      kind_in       = kind_ff;
      uop           = UOP_HOLD;
      tbl_we        = 1'b0;
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_budget_in = rsp_budget_ff;

      case (state_ff)
         ST_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            kind_in  = '0;
            if (req_valid) begin
               state_in = ST_FIN;
               case (op_type'(req_op))
                  OP_LOAD: begin
                     tbl_we = (int'(req_entry_index) < MAX_OPTIONS);
                  end
                  OP_BUDGET: begin
                     budget_in = req_budget_value;
                  end
                  OP_DRAW: begin
                     if (count_ff != '0) begin
                        uop      = UOP_CLEAR;
                        state_in = ST_SUM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SUM: begin
            uop = UOP_SUM;
            if (last_entry) begin
               idx_in   = '0;
               state_in = ST_MUL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MUL: begin
            uop    = UOP_MUL;
            idx_in = '0;
            if (status.total_zero) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            uop = UOP_SCAN;
            if (status.hit) begin
               found_in  = 1'b1;
               kind_in   = rd_data.kind;
               budget_in = budget_ff - {8'd0, rd_data.cost};
               state_in  = ST_FIN;
            end else if (last_entry) begin
               // scan ran out without crossing: fall back to the last eligible entry
               state_in = ST_FIN;
               if (status.eligible) begin
                  found_in  = 1'b1;
                  kind_in   = rd_data.kind;
                  budget_in = budget_ff - {8'd0, rd_data.cost};
               end else if (status.last_valid) begin
                  found_in  = 1'b1;
                  kind_in   = status.last_kind;
                  budget_in = budget_ff - {8'd0, status.last_cost};
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_kind_in   = kind_ff;
               rsp_budget_in = budget_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a pick never takes more than the budget holds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.hit) |-> ({8'd0, rd_data.cost} <= budget_ff))
      else $error("pick cost exceeds remaining budget");

   // a finished item lands in the result register and frees the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE && rsp_budget_ff == budget_ff))
      else $error("result not posted on finish");

   // budget moves only on a reload or a pick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM || state_ff == ST_MUL || state_ff == ST_FIN)
      |=> $stable(budget_ff))
      else $error("budget changed outside reload or pick");

endmodule

// ----- bench/bwrp_pick_checker.sv -----
// bwrp_pick_checker: watches the request, result and csr channels of the pick core,
// predicts every result from its own copy of the table, budget and option count and compares
// depends on bwrp_pkg
`timescale 1ns / 1ps

module bwrp_pick_checker
   import bwrp_pkg::*;
#(
   parameter int MAX_OPTIONS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [2:0]         req_entry_index,
   input  logic [7:0]         req_entry_type,
   input  logic [15:0]        req_entry_weight,
   input  logic [7:0]         req_entry_cost,
   input  logic signed [11:0] req_entry_min_height,
   input  logic signed [11:0] req_entry_max_height,
   input  logic [15:0]        req_budget_value,
   input  logic signed [11:0] req_height,
   input  logic [15:0]        req_roll,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_found,
   input  logic [7:0]         rsp_chosen_type,
   input  logic [15:0]        rsp_budget_left,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [3:0]         csr_option_count,
   output int                 fail_count,
   output int                 results_checked,
   output int                 pick_backlog
);

   typedef struct packed {
      logic        found;
      logic [7:0]  chosen_type;
      logic [15:0] budget_left;
   } pick_result_type;

   option_type      slots [MAX_OPTIONS];
   logic [15:0]     budget;
   logic [3:0]      active_options;
   pick_result_type pick_queue [$];

   function automatic pick_result_type apply_request(input op_type op, input logic [2:0] index,
                                                     input option_type entry,
                                                     input logic [15:0] new_budget,
                                                     input logic signed [11:0] height,
                                                     input logic [15:0] roll);
      int unsigned            used;
      logic [MAX_OPTIONS-1:0] eligible;
      logic [31:0]            total;
      logic [31:0]            running;
      logic [47:0]            scaled;
      int                     pick;
      int                     last;
      pick_result_type        res;
      res      = '0;
      eligible = '0;
      total    = '0;
      running  = '0;
      pick     = -1;
      last     = -1;
      case (op)
         OP_LOAD: begin
            if (index < MAX_OPTIONS) slots[index] = entry;
         end
         OP_BUDGET: begin
            budget = new_budget;
         end
         OP_DRAW: begin
            used = (active_options > MAX_OPTIONS) ? MAX_OPTIONS : active_options;
            for (int i = 0; i < used; i++) begin
               eligible[i] = slots[i].weight != 0 && slots[i].cost <= budget &&
                             $signed(height) >= $signed(slots[i].min_height) &&
                             $signed(height) <= $signed(slots[i].max_height);
               if (eligible[i]) begin
                  total += slots[i].weight;
                  last = i;
               end
            end
            if (total != 0) begin
               scaled = (48'(roll) * 48'(total)) >> 16;
               // first eligible entry whose running weight passes the scaled roll
               for (int i = 0; i < used && pick < 0; i++) begin
                  if (eligible[i]) begin
                     running += slots[i].weight;
                     if (scaled < 48'(running)) pick = i;
                  end
               end
               if (pick < 0) pick = last;
               budget          = budget - 16'(slots[pick].cost);
               res.found       = 1'b1;
               res.chosen_type = slots[pick].kind;
            end
         end
         default: ;
      endcase
      res.budget_left = budget;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      pick_result_type got;
      pick_result_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         budget         = '0;
         active_options = '0;
         pick_queue.delete();
         results_checked <= 0;
      end else begin
         if (csr_valid && csr_ready) active_options = csr_option_count;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_found, rsp_chosen_type, rsp_budget_left};
            results_checked <= results_checked + 1;
            if (pick_queue.size() == 0) begin
               $error("result transfer with no pending request");
               errs++;
            end else begin
               want = pick_queue.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, got.found);
                  errs++;
               end
               if (got.chosen_type !== want.chosen_type) begin
                  $error("chosen_type: expected 0x%0h, got 0x%0h",
                         want.chosen_type, got.chosen_type);
                  errs++;
               end
               if (got.budget_left !== want.budget_left) begin
                  $error("budget_left: expected %0d, got %0d",
                         want.budget_left, got.budget_left);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            pick_queue.push_back(apply_request(op_type'(req_op), req_entry_index,
                                               '{kind:       req_entry_type,
                                                 weight:     req_entry_weight,
                                                 cost:       req_entry_cost,
                                                 min_height: req_entry_min_height,
                                                 max_height: req_entry_max_height},
                                               req_budget_value, req_height, req_roll));
      end
      fail_count   <= fail_count + errs;
      pick_backlog <= pick_queue.size();
   end

endmodule

// ----- bench/tb_budgeted_weighted_random_pick_core.sv -----
// tb_budgeted_weighted_random_pick_core: directed and random stimulus for the pick core
// under varying idle and stall rates, with bwrp_pick_checker beside the block
// depends on bwrp_pkg, bwrp_pick_checker and budgeted_weighted_random_pick_core
`timescale 1ns / 1ps

module tb_budgeted_weighted_random_pick_core;
   import bwrp_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int ITEMS_PER_CHUNK = 211;

   typedef struct {
      op_type             op;
      logic [2:0]         index;
      option_type         entry;
      logic [15:0]        budget_value;
      logic signed [11:0] height;
      logic [15:0]        roll;
   } request_type;

   logic               clock                = 1'b0;
   logic               reset                = 1'b1;
   logic               req_valid            = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op               = '0;
   logic [2:0]         req_entry_index      = '0;
   logic [7:0]         req_entry_type       = '0;
   logic [15:0]        req_entry_weight     = '0;
   logic [7:0]         req_entry_cost       = '0;
   logic signed [11:0] req_entry_min_height = '0;
   logic signed [11:0] req_entry_max_height = '0;
   logic [15:0]        req_budget_value     = '0;
   logic signed [11:0] req_height           = '0;
   logic [15:0]        req_roll             = '0;
   logic               rsp_valid;
   logic               rsp_stall            = 1'b0;
   logic               rsp_found;
   logic [7:0]         rsp_chosen_type;
   logic [15:0]        rsp_budget_left;
   logic               csr_valid            = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_option_count     = '0;

   int fail_count;
   int results_checked;
   int pick_backlog;
   int items_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   budgeted_weighted_random_pick_core dut (.*);
   bwrp_pick_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall   <= $urandom_range(99) < rsp_stall_pct;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("budgeted_weighted_random_pick_core: mismatch");
         $finish;
      end
   end

   function automatic request_type random_request();
      request_type r;
      int unsigned sel;
      int          lo;
      int          hi;
      sel = $urandom_range(99);
      if (sel < 45)      r.op = OP_DRAW;
      else if (sel < 70) r.op = OP_LOAD;
      else if (sel < 85) r.op = OP_BUDGET;
      else               r.op = OP_NOP;
      r.index      = 3'($urandom);
      r.entry.kind = 8'($urandom);
      case ($urandom_range(9))
         0:       r.entry.weight = '0;
         1:       r.entry.weight = 16'hFFFF;
         2, 3, 4: r.entry.weight = 16'($urandom);
         default: r.entry.weight = 16'($urandom_range(16'h2000, 1));
      endcase
      r.entry.cost = ($urandom_range(4) < 2) ? 8'($urandom_range(8)) : 8'($urandom);
      // mostly wide or ordered bands so draws find candidates; some may come out empty
      case ($urandom_range(4))
         0, 1: begin
            lo = int'($urandom_range(1048)) - 2048;
            hi = int'($urandom_range(2047, 1000));
         end
         2, 3: begin
            lo = int'($urandom_range(4095)) - 2048;
            hi = int'($urandom_range(4095)) - 2048;
            if (lo > hi) {lo, hi} = {hi, lo};
         end
         default: begin
            lo = int'($urandom_range(4095)) - 2048;
            hi = int'($urandom_range(4095)) - 2048;
         end
      endcase
      r.entry.min_height = 12'(lo);
      r.entry.max_height = 12'(hi);
      case ($urandom_range(9))
         0:          r.budget_value = '0;
         1:          r.budget_value = 16'hFFFF;
         2, 3, 4, 5: r.budget_value = 16'($urandom);
         default:    r.budget_value = 16'($urandom_range(600));
      endcase
      r.height = ($urandom_range(9) < 7) ? 12'(int'($urandom_range(2400)) - 1200)
                                         : 12'($urandom);
      case ($urandom_range(19))
         0:       r.roll = '0;
         1:       r.roll = 16'hFFFF;
         default: r.roll = 16'($urandom);
      endcase
      return r;
   endfunction

   task automatic issue(input request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= r.op;
      req_entry_index      <= r.index;
      req_entry_type       <= r.entry.kind;
      req_entry_weight     <= r.entry.weight;
      req_entry_cost       <= r.entry.cost;
      req_entry_min_height <= r.entry.min_height;
      req_entry_max_height <= r.entry.max_height;
      req_budget_value     <= r.budget_value;
      req_height           <= r.height;
      req_roll             <= r.roll;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_checked < items_sent);
   endtask

   task automatic write_option_count(input logic [3:0] value);
      csr_valid        <= 1'b1;
      csr_option_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load(input logic [2:0] index, input logic [7:0] kind,
                       input logic [15:0] weight, input logic [7:0] cost,
                       input int lo, input int hi);
      request_type r;
      r                  = random_request();
      r.op               = OP_LOAD;
      r.index            = index;
      r.entry.kind       = kind;
      r.entry.weight     = weight;
      r.entry.cost       = cost;
      r.entry.min_height = 12'(lo);
      r.entry.max_height = 12'(hi);
      issue(r);
   endtask

   task automatic draw(input int height, input logic [15:0] roll);
      request_type r;
      r        = random_request();
      r.op     = OP_DRAW;
      r.height = 12'(height);
      r.roll   = roll;
      issue(r);
   endtask

   task automatic reload(input logic [15:0] value);
      request_type r;
      r              = random_request();
      r.op           = OP_BUDGET;
      r.budget_value = value;
      issue(r);
   endtask

   initial begin
      request_type r;
      int          chunk_counts [9];
      chunk_counts  = '{1, 8, 15, 3, 0, 6, 9, 2, 8};
      send_idle_pct = 17;
      rsp_stall_pct = 85;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no options in use: a draw finds nothing, then fill every slot
      write_option_count(4'd0);
      draw(0, 16'h8000);
      r    = random_request();
      r.op = OP_NOP;
      issue(r);
      reload(16'hFFFF);
      load(3'd0, 8'hFF, 16'hFFFF, 8'hFF, -2048, 2047);
      load(3'd1, 8'h00, 16'h0000, 8'h00, -2048, 2047);
      load(3'd2, 8'h5A, 16'h1000, 8'h00, 2047, 2047);
      load(3'd3, 8'hA5, 16'h0001, 8'd200, -2048, -2048);
      load(3'd4, 8'h11, 16'h0800, 8'd10, 100, -100);
      load(3'd5, 8'h22, 16'h8000, 8'hFF, 0, 0);
      load(3'd6, 8'h33, 16'h0001, 8'd1, -10, 10);
      load(3'd7, 8'h44, 16'h7FFF, 8'hFF, -2048, 2047);
      drain();

      write_option_count(4'd8);
      draw(0, 16'h0000);
      draw(0, 16'hFFFF);
      draw(2047, 16'($urandom));
      draw(-2048, 16'h0001);
      // cost equal to the budget still fits and empties it
      reload(16'd255);
      draw(0, 16'h0000);
      draw(0, 16'h4000);
      draw(2047, 16'hFFFF);
      reload(16'd254);
      draw(0, 16'hFFFF);
      drain();

      for (int c = 0; c < 9; c++) begin
         case (c / 3)
            0:       begin send_idle_pct = 17; rsp_stall_pct = 85; end
            1:       begin send_idle_pct = 85; rsp_stall_pct = 17; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         write_option_count(4'(chunk_counts[c]));
         repeat (ITEMS_PER_CHUNK) begin
            issue(random_request());
            if ($urandom_range(149) == 0) drain();
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pick_backlog == 0) begin
         $display("budgeted_weighted_random_pick_core: match");
      end else begin
         $display("budgeted_weighted_random_pick_core: mismatch");
      end
      $finish;
   end

endmodule
